/* hdl/mlt_pkg.sv */
// Package: shared types and codes for the MAC learning table.
`timescale 1ns / 1ps

package mlt_pkg;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_LEARN  = 3'd1;
    localparam logic [2:0] KIND_LOOKUP = 3'd2;
    localparam logic [2:0] KIND_SWEEP  = 3'd3;
    localparam logic [2:0] KIND_FLUSH  = 3'd4;
    localparam logic [2:0] KIND_MOVE   = 3'd5;
    localparam logic [2:0] KIND_READ   = 3'd6;
    localparam logic [2:0] KIND_SPARE  = 3'd7;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [1:0] REG_AGEING   = 2'd0;
    localparam logic [1:0] REG_FWDDELAY = 2'd1;
    localparam logic [1:0] REG_TOPO     = 2'd2;

    localparam logic [10:0] COUNT_MAX = 11'd2047;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [7:0]  port;
        logic        local_flag;
        logic [9:0]  slot;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_port;
        logic [47:0] out_mac;
        logic        out_local;
        logic [31:0] out_age;
        logic [10:0] removed_count;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [47:0] address;
        logic [7:0]  port;
        logic        local_flag;
        logic [31:0] stamp;
    } entry_t;

endpackage

/* hdl/mac_learning_table_core.sv */
// Top level: MAC learning table with ageing, one bucket row per memory word.
`timescale 1ns / 1ps

// The table is one synchronous memory of HASH_SIZE rows, each row holding the
// WAYS entries of one bucket, so a bucket is read and written back whole.
// After reset a clearing pass writes every row before the first transfer is
// taken. A tick or an unused kind goes straight to the finish state; learn,
// lookup and read slot pass two stages of reciprocal multiply for the bucket
// and slot split, the row read, then the write-back and the result; a read
// slot beyond the table goes to the finish state with a miss after the split.
// The result is valid from the cycle in which the next transfer can be taken.
// Age sweep and port flush walk every row with a read then a write. Moving a
// local address scans rows the same way until it finds the entry, then, unless
// it already sits in the target bucket, reads and writes the target bucket and
// clears the source entry. One item is in work at a time; the result sits in an
// output register so the next transfer can be taken while it waits, and a
// further result holds the block until that one is taken.
module mac_learning_table_core #(
    parameter int HASH_SIZE = 256,
    parameter int WAYS      = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mlt_pkg::req_t      req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mlt_pkg::rsp_t      rsp,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    localparam int HB = (HASH_SIZE > 1) ? $clog2(HASH_SIZE) : 1;
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NB = $clog2(WAYS + 1);
    localparam int TABLE_SLOTS = HASH_SIZE * WAYS;
    localparam logic [31:0] RECIP_H = 32'(((64'd1 << 32) + HASH_SIZE - 1) / HASH_SIZE);
    localparam logic [32:0] RECIP_W = 33'(((64'd1 << 32) + WAYS - 1) / WAYS);
    localparam logic [HB-1:0] LAST_ROW = HB'(HASH_SIZE - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_MOD  = 4'd3;
    localparam logic [3:0] S_BKT  = 4'd4;
    localparam logic [3:0] S_WRD  = 4'd5;
    localparam logic [3:0] S_WWR  = 4'd6;
    localparam logic [3:0] S_MRD  = 4'd7;
    localparam logic [3:0] S_MCHK = 4'd8;
    localparam logic [3:0] S_MDST = 4'd9;
    localparam logic [3:0] S_MCLR = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    typedef mlt_pkg::entry_t [WAYS-1:0] row_t;

    row_t mem [HASH_SIZE];
    row_t rd_data_reg;
    logic [HB-1:0] rd_addr, wr_addr;
    logic wr_en;
    row_t wr_data;

    logic [3:0] state_reg, state_next;
    logic [HB-1:0] row_cnt_reg, row_cnt_next;
    mlt_pkg::req_t req_reg, req_next;
    logic [17:0] x_reg, x_next;
    logic [17:0] qh_reg, qh_next;
    logic [9:0] qw_reg, qw_next;
    logic [HB-1:0] bucket_reg, bucket_next;
    logic [WB-1:0] way_reg, way_next;
    logic [10:0] cnt_reg, cnt_next;
    row_t src_row_reg, src_row_next;
    logic [WB-1:0] src_way_reg, src_way_next;
    mlt_pkg::rsp_t res_reg, res_next;
    mlt_pkg::rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic [31:0] now_reg, now_next;
    logic [30:0] ageing_reg, fdelay_reg;
    logic topo_reg;

    logic [49:0] prod_h;
    logic [41:0] prod_w;
    logic [31:0] rem_h, rem_w, thr;
    logic [HB-1:0] bucket_c, srow_c;
    logic [WB-1:0] way_c;
    logic slot_ok;

    function automatic logic [17:0] hash18(input logic [47:0] m);
        logic [17:0] x;
        x = {10'd0, m[47:40]};
        for (int i = 4; i >= 0; i--)
        begin
            x = (x << 2) ^ {10'd0, m[i*8 +: 8]};
        end
        return x ^ (x >> 8);
    endfunction

    function automatic logic is_expired(input mlt_pkg::entry_t e, input logic [31:0] t);
        logic [31:0] d;
        d = e.stamp - t;
        return !e.local_flag && ((d == 32'd0) || d[31]);
    endfunction

    function automatic mlt_pkg::rsp_t put_entry(input mlt_pkg::entry_t e,
                                                input logic [31:0] now);
        mlt_pkg::rsp_t r;
        r = '0;
        r.status = mlt_pkg::ST_HIT;
        r.out_port = e.port;
        r.out_mac = e.address;
        r.out_local = e.local_flag;
        r.out_age = e.local_flag ? 32'd0 : (now - e.stamp);
        return r;
    endfunction

    assign prod_h = 50'(x_reg) * 50'(RECIP_H);
    assign prod_w = 42'(req_reg.slot) * 42'(RECIP_W);
    assign rem_h = 32'(x_reg) - 32'(qh_reg) * 32'(HASH_SIZE);
    assign rem_w = 32'(req_reg.slot) - 32'(qw_reg) * 32'(WAYS);
    assign bucket_c = rem_h[HB-1:0];
    assign way_c = rem_w[WB-1:0];
    assign srow_c = HB'(qw_reg);
    assign slot_ok = 32'(req_reg.slot) < 32'(TABLE_SLOTS);
    assign thr = now_reg - (topo_reg ? {1'b0, fdelay_reg} : {1'b0, ageing_reg});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        row_t r;
        logic fn, fl, ff, fm;
        logic [WB-1:0] mn, ml, mf, mm, m;
        logic [NB-1:0] n;
        logic [11:0] sum;
        mlt_pkg::entry_t e;

        state_next = state_reg;
        row_cnt_next = row_cnt_reg;
        req_next = req_reg;
        x_next = x_reg;
        qh_next = qh_reg;
        qw_next = qw_reg;
        bucket_next = bucket_reg;
        way_next = way_reg;
        cnt_next = cnt_reg;
        src_row_next = src_row_reg;
        src_way_next = src_way_reg;
        res_next = res_reg;
        now_next = now_reg;
        rd_addr = row_cnt_reg;
        wr_en = 1'b0;
        wr_addr = row_cnt_reg;
        r = rd_data_reg;
        wr_data = r;
        fn = 1'b0; fl = 1'b0; ff = 1'b0; fm = 1'b0;
        mn = '0; ml = '0; mf = '0; mm = '0; m = '0;
        n = '0;
        sum = '0;
        e = r[0];

        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (r[i].valid && !r[i].local_flag && r[i].address == req_reg.mac)
            begin
                fn = 1'b1; mn = WB'(i);
            end
            if (r[i].valid && r[i].local_flag && r[i].address == req_reg.mac)
            begin
                fl = 1'b1; ml = WB'(i);
            end
            if (!r[i].valid)
            begin
                ff = 1'b1; mf = WB'(i);
            end
            if (r[i].valid && r[i].local_flag && r[i].port == req_reg.port)
            begin
                fm = 1'b1; mm = WB'(i);
            end
        end

        unique case (state_reg)
            S_CLR:
            begin
                wr_en = 1'b1;
                wr_data = '0;
                if (row_cnt_reg == LAST_ROW)
                begin
                    row_cnt_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    x_next = hash18(req.mac);
                    res_next = '0;
                    cnt_next = '0;
                    row_cnt_next = '0;
                    if (req.kind == mlt_pkg::KIND_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                        state_next = S_OUT;
                    end
                    else if (req.kind == mlt_pkg::KIND_LEARN || req.kind == mlt_pkg::KIND_LOOKUP
                             || req.kind == mlt_pkg::KIND_SWEEP
                             || req.kind == mlt_pkg::KIND_FLUSH
                             || req.kind == mlt_pkg::KIND_MOVE
                             || req.kind == mlt_pkg::KIND_READ)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV:
            begin
                qh_next = prod_h[49:32];
                qw_next = prod_w[41:32];
                state_next = S_MOD;
            end
            S_MOD:
            begin
                bucket_next = bucket_c;
                way_next = way_c;
                unique case (req_reg.kind)
                    mlt_pkg::KIND_LEARN, mlt_pkg::KIND_LOOKUP:
                    begin
                        rd_addr = bucket_c;
                        state_next = S_BKT;
                    end
                    mlt_pkg::KIND_READ:
                    begin
                        rd_addr = srow_c;
                        if (slot_ok)
                        begin
                            state_next = S_BKT;
                        end
                        else
                        begin
                            res_next.status = mlt_pkg::ST_MISS;
                            state_next = S_OUT;
                        end
                    end
                    mlt_pkg::KIND_SWEEP, mlt_pkg::KIND_FLUSH: state_next = S_WRD;
                    mlt_pkg::KIND_MOVE: state_next = S_MRD;
                    default: state_next = S_OUT;
                endcase
            end
            S_BKT:
            begin
                wr_addr = bucket_reg;
                state_next = S_OUT;
                unique case (req_reg.kind)
                    mlt_pkg::KIND_LEARN:
                    begin
                        wr_en = 1'b1;
                        if (fn)
                        begin
                            m = mn;
                        end
                        else if (req_reg.local_flag && fl)
                        begin
                            m = ml;
                        end
                        else if (ff)
                        begin
                            m = mf;
                            wr_data[m].valid = 1'b1;
                            wr_data[m].address = req_reg.mac;
                        end
                        else
                        begin
                            wr_en = 1'b0;
                            res_next.status = mlt_pkg::ST_FULL;
                        end
                        wr_data[m].port = req_reg.port;
                        wr_data[m].local_flag = req_reg.local_flag;
                        wr_data[m].stamp = now_reg;
                    end
                    mlt_pkg::KIND_LOOKUP:
                    begin
                        e = fn ? r[mn] : r[ml];
                        if ((fn || fl) && !is_expired(e, thr))
                        begin
                            res_next = put_entry(e, now_reg);
                        end
                        else
                        begin
                            res_next.status = mlt_pkg::ST_MISS;
                        end
                    end
                    default:
                    begin
                        e = r[way_reg];
                        if (e.valid)
                        begin
                            res_next = put_entry(e, now_reg);
                        end
                        else
                        begin
                            res_next.status = mlt_pkg::ST_MISS;
                        end
                    end
                endcase
            end
            S_WRD:
            begin
                state_next = S_WWR;
            end
            S_WWR:
            begin
                wr_en = 1'b1;
                for (int i = 0; i < WAYS; i++)
                begin
                    if (r[i].valid && ((req_reg.kind == mlt_pkg::KIND_SWEEP)
                                       ? is_expired(r[i], thr)
                                       : (r[i].port == req_reg.port)))
                    begin
                        wr_data[i].valid = 1'b0;
                        n = n + 1'b1;
                    end
                end
                sum = 12'(cnt_reg) + 12'(n);
                cnt_next = (sum > 12'(mlt_pkg::COUNT_MAX)) ? mlt_pkg::COUNT_MAX : sum[10:0];
                if (row_cnt_reg == LAST_ROW)
                begin
                    res_next.removed_count = cnt_next;
                    state_next = S_OUT;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_MRD:
            begin
                state_next = S_MCHK;
            end
            S_MCHK:
            begin
                if (fm)
                begin
                    src_row_next = r;
                    src_way_next = mm;
                    if (row_cnt_reg == bucket_reg)
                    begin
                        wr_en = 1'b1;
                        wr_data[mm].address = req_reg.mac;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rd_addr = bucket_reg;
                        state_next = S_MDST;
                    end
                end
                else if (row_cnt_reg == LAST_ROW)
                begin
                    res_next.status = mlt_pkg::ST_MISS;
                    state_next = S_OUT;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                    state_next = S_MRD;
                end
            end
            S_MDST:
            begin
                if (ff)
                begin
                    wr_en = 1'b1;
                    wr_addr = bucket_reg;
                    wr_data[mf] = src_row_reg[src_way_reg];
                    wr_data[mf].address = req_reg.mac;
                    state_next = S_MCLR;
                end
                else
                begin
                    res_next.status = mlt_pkg::ST_FULL;
                    state_next = S_OUT;
                end
            end
            S_MCLR:
            begin
                wr_en = 1'b1;
                wr_data = src_row_reg;
                wr_data[src_way_reg].valid = 1'b0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            row_cnt_reg <= '0;
            now_reg <= '0;
            rsp_valid_reg <= 1'b0;
            ageing_reg <= 31'd30000;
            fdelay_reg <= 31'd1500;
            topo_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_cnt_reg <= row_cnt_next;
            now_reg <= now_next;
            if (state_reg == S_OUT && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mlt_pkg::REG_AGEING:   ageing_reg <= cfg_data;
                    mlt_pkg::REG_FWDDELAY: fdelay_reg <= cfg_data;
                    mlt_pkg::REG_TOPO:     topo_reg <= cfg_data[0];
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        x_reg <= x_next;
        qh_reg <= qh_next;
        qw_reg <= qw_next;
        bucket_reg <= bucket_next;
        way_reg <= way_next;
        cnt_reg <= cnt_next;
        src_row_reg <= src_row_next;
        src_way_reg <= src_way_next;
        res_reg <= res_next;
        if (state_reg == S_OUT && (!rsp_valid_reg || rsp_ready))
        begin
            rsp_reg <= res_reg;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

`ifndef SYNTH
    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !req_ready)
        else $error("transfer offered during clearing pass");
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_OUT) |-> !wr_en)
        else $error("table written outside an item");
    a_result_loads_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !rsp_valid_reg) |=> rsp_valid_reg && state_reg == S_IDLE)
        else $error("result not delivered from finish state");
    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WWR && cnt_reg == mlt_pkg::COUNT_MAX) |=>
        cnt_reg == mlt_pkg::COUNT_MAX)
        else $error("removed count left saturation");
`endif

endmodule

/* tb/tb_mac_learning_table_core.sv */
// Testbench: random and directed traffic against a behavioural table model.
`timescale 1ns / 1ps

module tb_mac_learning_table_core;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    mlt_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    mlt_pkg::rsp_t rsp;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [30:0]   cfg_data;

    mac_learning_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    localparam int SLOTS = 1024;

    // model state
    logic        m_valid [SLOTS];
    logic [47:0] m_addr  [SLOTS];
    logic [7:0]  m_port  [SLOTS];
    logic        m_local [SLOTS];
    logic [31:0] m_stamp [SLOTS];
    logic [31:0] m_now;
    logic [30:0] m_ageing;
    logic [30:0] m_fwd;
    logic        m_topo;

    mlt_pkg::req_t cmd_queue [$];
    mlt_pkg::rsp_t answers [$];
    logic [47:0]   mac_pool [$];
    logic [7:0]    hot_bucket [3];
    int            fails;
    bit            quiet;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] bucket_of(logic [47:0] m);
        logic [31:0] x;
        x = {24'd0, m[47:40]};
        for (int i = 4; i >= 0; i--)
            x = (x << 2) ^ {24'd0, m[i*8 +: 8]};
        x = x ^ (x >> 8);
        return x[7:0];
    endfunction

    function automatic bit is_stale(int s);
        logic [31:0] t;
        logic [31:0] d;
        t = m_topo ? {1'b0, m_fwd} : {1'b0, m_ageing};
        if (m_local[s])
            return 1'b0;
        d = m_stamp[s] - (m_now - t);
        return (d == 32'd0) || d[31];
    endfunction

    function automatic int find_way(logic [7:0] b, logic [47:0] m, logic loc);
        for (int w = 0; w < 4; w++)
            if (m_valid[b*4+w] && m_local[b*4+w] == loc && m_addr[b*4+w] == m)
                return b*4+w;
        return -1;
    endfunction

    function automatic int free_way(logic [7:0] b);
        for (int w = 0; w < 4; w++)
            if (!m_valid[b*4+w])
                return b*4+w;
        return -1;
    endfunction

    function automatic mlt_pkg::rsp_t entry_rsp(int s);
        mlt_pkg::rsp_t r;
        r = '0;
        r.status    = mlt_pkg::ST_HIT;
        r.out_port  = m_port[s];
        r.out_mac   = m_addr[s];
        r.out_local = m_local[s];
        r.out_age   = m_local[s] ? 32'd0 : m_now - m_stamp[s];
        return r;
    endfunction

    function automatic mlt_pkg::rsp_t table_predict(mlt_pkg::req_t q);
        mlt_pkg::rsp_t r;
        logic [7:0]    b;
        int            m;
        int            d;
        logic [10:0]   cnt;
        r = '0;
        b = bucket_of(q.mac);
        cnt = '0;
        case (q.kind)
            mlt_pkg::KIND_TICK: m_now = m_now + 32'd1;
            mlt_pkg::KIND_LEARN:
            begin
                m = find_way(b, q.mac, 1'b0);
                if (m < 0 && q.local_flag)
                    m = find_way(b, q.mac, 1'b1);
                if (m < 0)
                begin
                    m = free_way(b);
                    if (m >= 0)
                    begin
                        m_valid[m] = 1'b1;
                        m_addr[m] = q.mac;
                    end
                end
                if (m < 0)
                    r.status = mlt_pkg::ST_FULL;
                else
                begin
                    m_port[m] = q.port;
                    m_local[m] = q.local_flag;
                    m_stamp[m] = m_now;
                end
            end
            mlt_pkg::KIND_LOOKUP:
            begin
                m = find_way(b, q.mac, 1'b0);
                if (m < 0)
                    m = find_way(b, q.mac, 1'b1);
                if (m < 0 || is_stale(m))
                    r.status = mlt_pkg::ST_MISS;
                else
                    r = entry_rsp(m);
            end
            mlt_pkg::KIND_SWEEP, mlt_pkg::KIND_FLUSH:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (m_valid[s] && ((q.kind == mlt_pkg::KIND_SWEEP)
                                       ? is_stale(s) : m_port[s] == q.port))
                    begin
                        m_valid[s] = 1'b0;
                        if (cnt != mlt_pkg::COUNT_MAX)
                            cnt++;
                    end
                r.removed_count = cnt;
            end
            mlt_pkg::KIND_MOVE:
            begin
                m = -1;
                for (int s = 0; s < SLOTS && m < 0; s++)
                    if (m_valid[s] && m_local[s] && m_port[s] == q.port)
                        m = s;
                if (m < 0)
                    r.status = mlt_pkg::ST_MISS;
                else
                begin
                    d = m;
                    if (m / 4 != b)
                        d = free_way(b);
                    if (d < 0)
                        r.status = mlt_pkg::ST_FULL;
                    else
                    begin
                        if (d != m)
                        begin
                            m_valid[d] = 1'b1;
                            m_port[d] = m_port[m];
                            m_local[d] = m_local[m];
                            m_stamp[d] = m_stamp[m];
                            m_valid[m] = 1'b0;
                        end
                        m_addr[d] = q.mac;
                    end
                end
            end
            mlt_pkg::KIND_READ:
            begin
                if (m_valid[q.slot])
                    r = entry_rsp(q.slot);
                else
                    r.status = mlt_pkg::ST_MISS;
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && req_ready)
                answers.push_back(table_predict(req));
            if (!req_valid || req_ready)
            begin
                if (cmd_queue.size() > 0 && (quiet || $urandom_range(99) >= 34))
                begin
                    req <= cmd_queue.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (answers.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected transfer: %p", rsp);
                end
                else if (answers[0] !== rsp)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: expected %p actual %p", answers[0], rsp);
                    void'(answers.pop_front());
                end
                else
                    void'(answers.pop_front());
            end
            rsp_ready <= quiet || ($urandom_range(99) >= 34);
        end
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom_range(65535)), $urandom()};
    endfunction

    function automatic logic [7:0] small_port();
        return ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
    endfunction

    function automatic mlt_pkg::req_t rand_item();
        mlt_pkg::req_t q;
        int            k;
        q = '0;
        q.mac = ($urandom_range(9) < 7) ? mac_pool[$urandom_range(mac_pool.size() - 1)]
                                        : rand_mac();
        q.port = small_port();
        q.local_flag = ($urandom_range(3) == 0);
        q.slot = ($urandom_range(1) == 0)
                 ? {hot_bucket[$urandom_range(2)], 2'($urandom())} : 10'($urandom());
        k = $urandom_range(99);
        if (k < 20)
            q.kind = mlt_pkg::KIND_TICK;
        else if (k < 48)
            q.kind = mlt_pkg::KIND_LEARN;
        else if (k < 73)
            q.kind = mlt_pkg::KIND_LOOKUP;
        else if (k < 77)
            q.kind = mlt_pkg::KIND_SWEEP;
        else if (k < 80)
            q.kind = mlt_pkg::KIND_FLUSH;
        else if (k < 86)
            q.kind = mlt_pkg::KIND_MOVE;
        else if (k < 98)
            q.kind = mlt_pkg::KIND_READ;
        else
            q.kind = mlt_pkg::KIND_SPARE;
        return q;
    endfunction

    function automatic mlt_pkg::req_t mk(logic [2:0] k, logic [47:0] m, logic [7:0] p,
                                         logic l, logic [9:0] s);
        mlt_pkg::req_t q;
        q.kind = k;
        q.mac = m;
        q.port = p;
        q.local_flag = l;
        q.slot = s;
        return q;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            mlt_pkg::REG_AGEING:   m_ageing = val;
            mlt_pkg::REG_FWDDELAY: m_fwd = val;
            default:               m_topo = val[0];
        endcase
    endtask

    task automatic settle();
        while (cmd_queue.size() > 0 || answers.size() > 0 || req_valid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        logic [47:0] c;
        logic [30:0] ag [5];
        logic [30:0] fd [5];
        logic        tp [5];
        ag = '{31'd30000, 31'd12, 31'd40, 31'd0, 31'h7FFFFFFF};
        fd = '{31'd1500, 31'd3, 31'd6, 31'h7FFFFFFF, 31'd0};
        tp = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        fails = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mlt_pkg::REG_AGEING;
        cfg_data = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            m_valid[s] = 1'b0;
            m_addr[s] = '0;
            m_port[s] = '0;
            m_local[s] = 1'b0;
            m_stamp[s] = '0;
        end
        m_now = '0;
        m_ageing = 31'd30000;
        m_fwd = 31'd1500;
        m_topo = 1'b0;
        for (int i = 0; i < 3; i++)
            hot_bucket[i] = 8'($urandom());
        while (mac_pool.size() < 18)
        begin
            c = rand_mac();
            if (bucket_of(c) == hot_bucket[mac_pool.size() % 3])
                mac_pool.push_back(c);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        cmd_queue.push_back(mk(mlt_pkg::KIND_READ, '0, '0, 1'b0, 10'd0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_LEARN, '0, 8'd0, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_LEARN, '1, 8'd255, 1'b1, '1));
        cmd_queue.push_back(mk(mlt_pkg::KIND_LOOKUP, '0, '0, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_LOOKUP, '1, '0, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_LEARN, '1, 8'd7, 1'b1, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_LEARN, '1, 8'd9, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_LOOKUP, '1, '0, 1'b0, '0));
        for (int i = 0; i < 15; i += 3)
            cmd_queue.push_back(mk(mlt_pkg::KIND_LEARN, mac_pool[i], 8'(i), 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_READ, '0, '0, 1'b0, {hot_bucket[0], 2'd3}));
        cmd_queue.push_back(mk(mlt_pkg::KIND_MOVE, mac_pool[3], 8'd7, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_MOVE, mac_pool[1], 8'd200, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_TICK, '0, '0, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_SWEEP, '0, '0, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_FLUSH, '0, 8'd255, 1'b0, '0));
        cmd_queue.push_back(mk(mlt_pkg::KIND_SPARE, '1, '1, 1'b1, '1));
        cmd_queue.push_back(mk(mlt_pkg::KIND_READ, '1, '1, 1'b1, 10'd1023));
        settle();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(mlt_pkg::REG_AGEING, ag[ph]);
            write_reg(mlt_pkg::REG_FWDDELAY, fd[ph]);
            write_reg(mlt_pkg::REG_TOPO, {30'd0, tp[ph]});
            @(posedge clk);
            cfg_we <= 1'b0;
            quiet = (ph == 2);
            for (int i = 0; i < 340; i++)
                cmd_queue.push_back(rand_item());
            settle();
        end

        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("mac_learning_table_core regression: pass");
        else
            $display("mac_learning_table_core regression: fail");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("mac_learning_table_core regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mlt_pkg.sv
hdl/mac_learning_table_core.sv
tb/tb_mac_learning_table_core.sv
